// ----- design/dq_pkg.sv -----
// Package for the double-ended queue: sizes, command and status codes,
// the stage record passed from the pointer stage to the result stage.
// No dependencies.
package dq_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE_AT   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // Source of the returned word
    localparam logic [1:0] DSEL_ZERO  = 2'd0;
    localparam logic [1:0] DSEL_MEM   = 2'd1;
    localparam logic [1:0] DSEL_FRONT = 2'd2;
    localparam logic [1:0] DSEL_BACK  = 2'd3;

    // Update of the front and back shadow words
    localparam logic [1:0] USEL_KEEP  = 2'd0;
    localparam logic [1:0] USEL_VALUE = 2'd1;
    localparam logic [1:0] USEL_MEM   = 2'd2;

    typedef struct packed {
        logic [1:0]               data_sel;
        logic [1:0]               front_sel;
        logic [1:0]               back_sel;
        logic signed [WORD_W-1:0] value;
        logic [CNT_W-1:0]         count;
        logic [STAT_W-1:0]        status;
    } t_stage;

    // Ring slot of the entry k places behind the head (k below DEPTH)
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(k);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ----- design/dq_if.sv -----
// Handshake channels of the double-ended queue: command words in, result
// words out. Depends on dq_pkg for field widths.
interface dq_in_if;
    logic                             valid;
    logic                             ready;
    logic [dq_pkg::CMD_W-1:0]         cmd;
    logic signed [dq_pkg::WORD_W-1:0] value;
    logic [dq_pkg::POS_W-1:0]         position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface dq_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dq_pkg::WORD_W-1:0] data_out;
    logic [dq_pkg::CNT_W-1:0]         count;
    logic signed [dq_pkg::WORD_W-1:0] front_word;
    logic signed [dq_pkg::WORD_W-1:0] back_word;
    logic [dq_pkg::STAT_W-1:0]        status;

    modport source (output valid, data_out, count, front_word, back_word, status,
                    input ready);
    modport sink   (input valid, data_out, count, front_word, back_word, status,
                    output ready);
endinterface

// ----- design/dq_ctrl.sv -----
// Pointer stage: head and count, the entry memory, and the stage register
// handed on to the result stage. Depends on dq_pkg.
module dq_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_advance,
    input  logic [dq_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [dq_pkg::WORD_W-1:0] i_value,
    input  logic [dq_pkg::POS_W-1:0]         i_position,
    output logic                             o_stage_valid,
    output dq_pkg::t_stage                   o_stage,
    output logic signed [dq_pkg::WORD_W-1:0] o_rd_word
);

    logic signed [dq_pkg::WORD_W-1:0] r_mem [dq_pkg::DEPTH];

    logic [dq_pkg::PTR_W-1:0] r_head, n_head;
    logic [dq_pkg::CNT_W-1:0] r_count, n_count;
    logic                     r_stage_valid, n_stage_valid;
    dq_pkg::t_stage           r_stage, n_stage;
    logic signed [dq_pkg::WORD_W-1:0] r_rd_word;

    logic                     wr_en;
    logic [dq_pkg::PTR_W-1:0] wr_addr;
    logic [dq_pkg::PTR_W-1:0] rd_addr;
    logic [dq_pkg::CNT_W-1:0] pos_ext;
    logic [dq_pkg::CNT_W-1:0] last_k;
    logic [dq_pkg::CNT_W-1:0] prev_k;
    logic                     is_full;
    logic                     is_empty;
    logic                     in_range;

    always_comb begin
        is_full  = (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
        is_empty = (r_count == '0);
        pos_ext  = dq_pkg::CNT_W'(i_position);
        in_range = (pos_ext < r_count);
        last_k   = is_empty ? '0 : r_count - 1'b1;
        // offset of the entry that becomes the back after a pop from the back
        prev_k   = (r_count >= dq_pkg::CNT_W'(2)) ? r_count - dq_pkg::CNT_W'(2) : '0;

        n_head   = r_head;
        n_count  = r_count;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_addr  = '0;

        n_stage.data_sel  = dq_pkg::DSEL_ZERO;
        n_stage.front_sel = dq_pkg::USEL_KEEP;
        n_stage.back_sel  = dq_pkg::USEL_KEEP;
        n_stage.value     = i_value;
        n_stage.status    = dq_pkg::ST_OK;

        unique case (i_cmd)
            dq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_stage.status = dq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = dq_pkg::slot_of(r_head, r_count);
                    n_count = r_count + 1'b1;
                    n_stage.back_sel  = dq_pkg::USEL_VALUE;
                    n_stage.front_sel = is_empty ? dq_pkg::USEL_VALUE : dq_pkg::USEL_KEEP;
                end
            end
            dq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_stage.status = dq_pkg::ST_FULL;
                end else begin
                    n_head  = (r_head == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                                             : r_head - 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    n_count = r_count + 1'b1;
                    n_stage.front_sel = dq_pkg::USEL_VALUE;
                    n_stage.back_sel  = is_empty ? dq_pkg::USEL_VALUE : dq_pkg::USEL_KEEP;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    n_stage.status = dq_pkg::ST_EMPTY;
                end else begin
                    rd_addr = dq_pkg::slot_of(r_head, prev_k);
                    n_count = r_count - 1'b1;
                    n_stage.data_sel = dq_pkg::DSEL_BACK;
                    n_stage.back_sel = dq_pkg::USEL_MEM;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                    n_stage.status = dq_pkg::ST_EMPTY;
                end else begin
                    n_head  = dq_pkg::slot_of(r_head, dq_pkg::CNT_W'(1));
                    rd_addr = n_head;
                    n_count = r_count - 1'b1;
                    n_stage.data_sel  = dq_pkg::DSEL_FRONT;
                    n_stage.front_sel = dq_pkg::USEL_MEM;
                end
            end
            dq_pkg::CMD_READ_AT: begin
                if (!in_range) begin
                    n_stage.status = dq_pkg::ST_RANGE;
                end else begin
                    rd_addr = dq_pkg::slot_of(r_head, pos_ext);
                    n_stage.data_sel = dq_pkg::DSEL_MEM;
                end
            end
            dq_pkg::CMD_WRITE_AT: begin
                if (!in_range) begin
                    n_stage.status = dq_pkg::ST_RANGE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = dq_pkg::slot_of(r_head, pos_ext);
                    n_stage.front_sel = (pos_ext == '0) ? dq_pkg::USEL_VALUE
                                                        : dq_pkg::USEL_KEEP;
                    n_stage.back_sel  = (pos_ext == last_k) ? dq_pkg::USEL_VALUE
                                                            : dq_pkg::USEL_KEEP;
                end
            end
            dq_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase

        n_stage.count = n_count;
        n_stage_valid = i_accept ? 1'b1 : (i_advance ? 1'b0 : r_stage_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= n_stage_valid;
            if (i_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stage <= n_stage;
        end
    end

    // Entry memory: at most one write and one registered read per accepted word
    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    assign o_stage_valid = r_stage_valid;
    assign o_stage       = r_stage;
    assign o_rd_word     = r_rd_word;

endmodule

// ----- design/dq_result.sv -----
// Result stage: front and back shadow words and the output register.
// Depends on dq_pkg.
module dq_result (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_out_ready,
    input  dq_pkg::t_stage                   i_stage,
    input  logic signed [dq_pkg::WORD_W-1:0] i_rd_word,
    output logic                             o_out_valid,
    output logic signed [dq_pkg::WORD_W-1:0] o_data_out,
    output logic [dq_pkg::CNT_W-1:0]         o_count,
    output logic signed [dq_pkg::WORD_W-1:0] o_front_word,
    output logic signed [dq_pkg::WORD_W-1:0] o_back_word,
    output logic [dq_pkg::STAT_W-1:0]        o_status
);

    logic signed [dq_pkg::WORD_W-1:0] r_front, n_front;
    logic signed [dq_pkg::WORD_W-1:0] r_back, n_back;
    logic                             r_out_valid, n_out_valid;
    logic signed [dq_pkg::WORD_W-1:0] r_data_out, n_data_out;
    logic [dq_pkg::CNT_W-1:0]         r_count;
    logic signed [dq_pkg::WORD_W-1:0] r_front_word;
    logic signed [dq_pkg::WORD_W-1:0] r_back_word;
    logic [dq_pkg::STAT_W-1:0]        r_status;
    logic                             now_empty;

    always_comb begin
        unique case (i_stage.front_sel)
            dq_pkg::USEL_VALUE: n_front = i_stage.value;
            dq_pkg::USEL_MEM:   n_front = i_rd_word;
            default:            n_front = r_front;
        endcase
        unique case (i_stage.back_sel)
            dq_pkg::USEL_VALUE: n_back = i_stage.value;
            dq_pkg::USEL_MEM:   n_back = i_rd_word;
            default:            n_back = r_back;
        endcase
        // a popped word comes from the shadows as they stood before this word
        unique case (i_stage.data_sel)
            dq_pkg::DSEL_MEM:   n_data_out = i_rd_word;
            dq_pkg::DSEL_FRONT: n_data_out = r_front;
            dq_pkg::DSEL_BACK:  n_data_out = r_back;
            default:            n_data_out = '0;
        endcase
        now_empty   = (i_stage.count == '0);
        n_out_valid = i_advance ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_front      <= n_front;
            r_back       <= n_back;
            r_data_out   <= n_data_out;
            r_count      <= i_stage.count;
            r_status     <= i_stage.status;
            r_front_word <= now_empty ? '0 : n_front;
            r_back_word  <= now_empty ? '0 : n_back;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_data_out;
    assign o_count      = r_count;
    assign o_front_word = r_front_word;
    assign o_back_word  = r_back_word;
    assign o_status     = r_status;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the double-ended queue: handshake control around the pointer
// stage and the result stage. Depends on dq_pkg, dq_if, dq_ctrl, dq_result.
//
//   port     dir   word carried                                  handshake
//   i_in     in    cmd, value, position                          valid/ready
//   o_out    out   data_out, count, front_word, back_word, status valid/ready
//
// One word per cycle sustained while the output is not stalled; each result
// is registered in the pointer stage (memory access and pointer update),
// then in the result stage. A command reads at most one entry, the front
// and back words live in shadow registers.
// Reset clears head, count and both valid flags; the memory keeps its data.
// A stall at the output holds the result and the staged word; new commands
// are taken while the stage is empty or the staged word can move on.
module double_ended_queue (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_in_if.sink    i_in,
    dq_out_if.source o_out
);

    logic           stage_valid;
    logic           out_valid;
    logic           out_free;
    logic           advance;
    logic           accept;
    dq_pkg::t_stage stage;
    logic signed [dq_pkg::WORD_W-1:0] rd_word;

    assign out_free   = !out_valid || o_out.ready;
    assign advance    = stage_valid && out_free;
    assign i_in.ready = !stage_valid || out_free;
    assign accept     = i_in.valid && i_in.ready;

    dq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_advance     (advance),
        .i_cmd         (i_in.cmd),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .o_stage_valid (stage_valid),
        .o_stage       (stage),
        .o_rd_word     (rd_word)
    );

    dq_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_out_ready  (o_out.ready),
        .i_stage      (stage),
        .i_rd_word    (rd_word),
        .o_out_valid  (out_valid),
        .o_data_out   (o_out.data_out),
        .o_count      (o_out.count),
        .o_front_word (o_out.front_word),
        .o_back_word  (o_out.back_word),
        .o_status     (o_out.status)
    );

    assign o_out.valid = out_valid;

endmodule

// ----- design/dq_checker.sv -----
// Port checks for the double-ended queue and the bind that attaches them
// to the top level. Depends on dq_pkg and double_ended_queue.
module dq_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [dq_pkg::WORD_W-1:0] i_data_out,
    input  logic [dq_pkg::CNT_W-1:0]         i_count,
    input  logic signed [dq_pkg::WORD_W-1:0] i_front_word,
    input  logic signed [dq_pkg::WORD_W-1:0] i_back_word,
    input  logic [dq_pkg::STAT_W-1:0]        i_status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_data_out) && $stable(i_count))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("count beyond depth");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count == '0 |-> i_front_word == '0 && i_back_word == '0)
        else $error("front or back word shown on an empty queue");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == dq_pkg::ST_FULL |->
            i_count == dq_pkg::CNT_W'(dq_pkg::DEPTH) && i_data_out == '0)
        else $error("full flagged below depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == dq_pkg::ST_EMPTY |->
            i_count == '0 && i_data_out == '0)
        else $error("empty flagged on a non-empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_out   (o_out.data_out),
    .i_count      (o_out.count),
    .i_front_word (o_out.front_word),
    .i_back_word  (o_out.back_word),
    .i_status     (o_out.status)
);
